[sv/zmsf_pkg.sv]
`timescale 1ns / 1ps

package zmsf_pkg;

  // Configuration register
  localparam int ZONE_SIZE_W   = 7;
  localparam int ZONE_SIZE_RST = 8;

  // Field widths
  localparam int ACTION_W = 2;
  localparam int KEY_W    = 32;

  // Defaults for the top-level parameters
  localparam int MAX_ELEMENTS_DEF  = 64;
  localparam int ELEMENT_WIDTH_DEF = 32;

  // Command queue between front and back
  localparam int CMDQ_DEPTH = 2;

  typedef enum logic [ACTION_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_POINT = 2'd1,
    OP_RANGE = 2'd2,
    OP_CLEAR = 2'd3
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e                  op;
    logic signed [KEY_W-1:0]  lo;
    logic signed [KEY_W-1:0]  hi;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ZRD,
    BK_ZCHK,
    BK_ESCAN,
    BK_FIN
  } bk_state_e;

endpackage

[sv/zone_map_scan_filter.sv]
`timescale 1ns / 1ps
// Zone-map filtered element store.
// Input channel (in_valid_i / in_stall_o) takes one item per accept: action_i
// selects load, point query, range query or clear; value_i is the element,
// key or lower bound; upper_i is the inclusive upper bound of a range query.
// Output channel (out_valid_o / out_stall_i) returns result items; last_o
// marks the final result of an input item. The zone size register is written
// through cfg_we_i / cfg_wdata_i; the user must write it only while the block
// is idle, which the block itself does not enforce. Load and clear give one
// result each. A query reads the zone entry of every stored zone it examines
// and scans the elements of every zone whose min/max admits the key. The rate
// is set by the single read port of the element store and zone table.
// A two-entry command queue lets the next items be accepted during a scan.
// Reset empties the store and sets the zone size to 8; no memory sweep.
// When the receiver stalls, the output register holds its result and the
// scan pauses; the input side stalls once the command queue fills.
module zone_map_scan_filter #(
  parameter int MAX_ELEMENTS  = zmsf_pkg::MAX_ELEMENTS_DEF,
  parameter int ELEMENT_WIDTH = zmsf_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [zmsf_pkg::ZONE_SIZE_W-1:0]    cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [zmsf_pkg::ACTION_W-1:0]       action_i,
  input  logic signed [zmsf_pkg::KEY_W-1:0]   value_i,
  input  logic signed [zmsf_pkg::KEY_W-1:0]   upper_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                found_o,
  output logic                                match_valid_o,
  output logic signed [zmsf_pkg::KEY_W-1:0]   match_value_o,
  output logic                                last_o,
  output logic                                store_full_o
);

  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_vld;
  zmsf_pkg::cmd_t f_cmd;
  zmsf_pkg::cmd_t q_cmd;

  // Accept and classify
  zmsf_front #(
    .ELEMENT_WIDTH(ELEMENT_WIDTH)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .value_i    (value_i),
    .upper_i    (upper_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .cmd_o      (f_cmd)
  );

  // Decouple front from back
  zmsf_cmd_fifo u_cmdq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (f_cmd),
    .full_o (q_full),
    .pop_i  (q_pop),
    .vld_o  (q_vld),
    .cmd_o  (q_cmd)
  );

  // Execute against the store
  zmsf_back #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .ELEMENT_WIDTH(ELEMENT_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .q_vld_i       (q_vld),
    .q_cmd_i       (q_cmd),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .found_o       (found_o),
    .match_valid_o (match_valid_o),
    .match_value_o (match_value_o),
    .last_o        (last_o),
    .store_full_o  (store_full_o)
  );

endmodule

[sv/zmsf_front.sv]
`timescale 1ns / 1ps

module zmsf_front #(
  parameter int ELEMENT_WIDTH = zmsf_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [zmsf_pkg::ACTION_W-1:0]       action_i,
  input  logic signed [zmsf_pkg::KEY_W-1:0]   value_i,
  input  logic signed [zmsf_pkg::KEY_W-1:0]   upper_i,
  input  logic                                q_full_i,
  output logic                                push_o,
  output zmsf_pkg::cmd_t                      cmd_o
);

  localparam int StoreW = (ELEMENT_WIDTH < zmsf_pkg::KEY_W) ? ELEMENT_WIDTH : zmsf_pkg::KEY_W;

  logic signed [StoreW-1:0] lo_trunc;
  logic signed [StoreW-1:0] hi_trunc;
  zmsf_pkg::cmd_op_e        op;

  // Accept whenever the queue has room
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // Classify the action code
  always_comb begin
    unique case (action_i)
      zmsf_pkg::OP_LOAD:  op = zmsf_pkg::OP_LOAD;
      zmsf_pkg::OP_POINT: op = zmsf_pkg::OP_POINT;
      zmsf_pkg::OP_RANGE: op = zmsf_pkg::OP_RANGE;
      default:            op = zmsf_pkg::OP_CLEAR;
    endcase
  end

  // Narrow to the element width, then sign-extend back to a full key
  assign lo_trunc = value_i[StoreW-1:0];
  assign hi_trunc = upper_i[StoreW-1:0];

  assign cmd_o.op = op;
  assign cmd_o.lo = zmsf_pkg::KEY_W'(lo_trunc);
  assign cmd_o.hi = zmsf_pkg::KEY_W'(hi_trunc);

endmodule

[sv/zmsf_cmd_fifo.sv]
`timescale 1ns / 1ps

module zmsf_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  zmsf_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           vld_o,
  output zmsf_pkg::cmd_t cmd_o
);

  localparam int PtrW = $clog2(zmsf_pkg::CMDQ_DEPTH);
  localparam int CntW = $clog2(zmsf_pkg::CMDQ_DEPTH + 1);

  zmsf_pkg::cmd_t slot_q [zmsf_pkg::CMDQ_DEPTH];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o = (cnt_q == CntW'(zmsf_pkg::CMDQ_DEPTH));
  assign vld_o  = (cnt_q != '0);
  assign cmd_o  = slot_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // Hold queued items
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

[sv/zmsf_back.sv]
`timescale 1ns / 1ps

module zmsf_back #(
  parameter int MAX_ELEMENTS  = zmsf_pkg::MAX_ELEMENTS_DEF,
  parameter int ELEMENT_WIDTH = zmsf_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [zmsf_pkg::ZONE_SIZE_W-1:0]      cfg_wdata_i,
  input  logic                                  q_vld_i,
  input  zmsf_pkg::cmd_t                        q_cmd_i,
  output logic                                  q_pop_o,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  found_o,
  output logic                                  match_valid_o,
  output logic signed [zmsf_pkg::KEY_W-1:0]     match_value_o,
  output logic                                  last_o,
  output logic                                  store_full_o
);

  localparam int StoreW = (ELEMENT_WIDTH < zmsf_pkg::KEY_W) ? ELEMENT_WIDTH : zmsf_pkg::KEY_W;
  localparam int CntW   = $clog2(MAX_ELEMENTS + 1);
  localparam int AddrW  = $clog2(MAX_ELEMENTS);
  localparam int ZsW    = zmsf_pkg::ZONE_SIZE_W;
  localparam int KeyW   = zmsf_pkg::KEY_W;

  // Element store and zone table
  logic signed [StoreW-1:0] elem_mem  [MAX_ELEMENTS];
  logic [CntW-1:0]          zstart_mem[MAX_ELEMENTS];
  logic [CntW-1:0]          zend_mem  [MAX_ELEMENTS];
  logic signed [StoreW-1:0] zmin_mem  [MAX_ELEMENTS];
  logic signed [StoreW-1:0] zmax_mem  [MAX_ELEMENTS];

  zmsf_pkg::bk_state_e state_q, state_d;

  logic [ZsW-1:0]           zone_size_q;
  logic [CntW-1:0]          cnt_q;
  logic [ZsW-1:0]           pos_q;
  logic [CntW-1:0]          ztot_q;
  logic [CntW-1:0]          cur_start_q;
  logic signed [StoreW-1:0] cur_min_q;
  logic signed [StoreW-1:0] cur_max_q;

  zmsf_pkg::cmd_op_e        op_q;
  logic signed [KeyW-1:0]   lo_q;
  logic signed [KeyW-1:0]   hi_q;
  logic [CntW-1:0]          z_q;
  logic [CntW-1:0]          zs_q;
  logic [CntW-1:0]          ze_q;
  logic signed [StoreW-1:0] zmn_q;
  logic signed [StoreW-1:0] zmx_q;
  logic [CntW-1:0]          idx_q;
  logic [CntW-1:0]          end_q;
  logic signed [StoreW-1:0] erd_q;
  logic                     vld_b_q;
  logic                     hit_q;
  logic                     pend_vld_q;
  logic signed [KeyW-1:0]   pend_val_q;

  logic                     out_vld_q;
  logic                     found_q;
  logic                     mvld_q;
  logic signed [KeyW-1:0]   mval_q;
  logic                     last_q;
  logic                     full_q;

  // Control from the output block
  logic                     out_can;
  logic                     advance;
  logic                     issue_ok;
  logic                     scan_done;
  logic                     zone_hit;
  logic                     point_match;
  logic                     range_match;
  logic                     q_pop;
  logic                     q_start;
  logic                     do_load;
  logic                     do_clear;
  logic                     zrd_en;
  logic                     erd_en;
  logic                     emit;
  logic                     e_found;
  logic                     e_mvld;
  logic signed [KeyW-1:0]   e_mval;
  logic                     e_last;
  logic                     e_full;

  // Load datapath
  logic [ZsW-1:0]           zs_eff;
  logic                     is_full;
  logic                     new_zone;
  logic signed [StoreW-1:0] ld_key;
  logic signed [StoreW-1:0] nmin;
  logic signed [StoreW-1:0] nmax;
  logic [CntW-1:0]          nstart;
  logic [AddrW-1:0]         zaddr;
  logic [CntW-1:0]          nend;

  // Scan datapath
  logic signed [KeyW-1:0]   e_key;
  logic signed [KeyW-1:0]   zmn_key;
  logic signed [KeyW-1:0]   zmx_key;

  assign e_key   = KeyW'(erd_q);
  assign zmn_key = KeyW'(zmn_q);
  assign zmx_key = KeyW'(zmx_q);

  assign out_can   = !out_vld_q || !out_stall_i;
  assign advance   = (state_q == zmsf_pkg::BK_ESCAN) && out_can;
  assign issue_ok  = (idx_q < end_q);
  assign scan_done = !issue_ok && !vld_b_q;

  // Zone bounds test: key inside for a point query, overlap for a range
  always_comb begin
    if (op_q == zmsf_pkg::OP_POINT) begin
      zone_hit = (lo_q >= zmn_key) && (lo_q <= zmx_key);
    end else begin
      zone_hit = !(lo_q > zmx_key) && !(hi_q < zmn_key);
    end
  end

  assign point_match = advance && vld_b_q && (op_q == zmsf_pkg::OP_POINT) && (e_key == lo_q);
  assign range_match = advance && vld_b_q && (op_q == zmsf_pkg::OP_RANGE) &&
                       (e_key >= lo_q) && (e_key <= hi_q);

  // Where the next load lands
  assign zs_eff   = (zone_size_q == '0) ? ZsW'(1) : zone_size_q;
  assign is_full  = (cnt_q >= CntW'(MAX_ELEMENTS));
  assign new_zone = (pos_q == '0) || (pos_q >= zs_eff) || (ztot_q == '0);
  assign ld_key   = q_cmd_i.lo[StoreW-1:0];
  assign nend     = cnt_q + CntW'(1);

  always_comb begin
    if (new_zone) begin
      nmin   = ld_key;
      nmax   = ld_key;
      nstart = cnt_q;
      zaddr  = ztot_q[AddrW-1:0];
    end else begin
      nmin   = (ld_key < cur_min_q) ? ld_key : cur_min_q;
      nmax   = (ld_key > cur_max_q) ? ld_key : cur_max_q;
      nstart = cur_start_q;
      zaddr  = AddrW'(ztot_q - CntW'(1));
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      zmsf_pkg::BK_IDLE: begin
        if (q_vld_i) begin
          case (q_cmd_i.op) inside
            zmsf_pkg::OP_POINT, zmsf_pkg::OP_RANGE: state_d = zmsf_pkg::BK_ZRD;
            default:                                state_d = zmsf_pkg::BK_IDLE;
          endcase
        end
      end
      zmsf_pkg::BK_ZRD: begin
        state_d = (z_q == ztot_q) ? zmsf_pkg::BK_FIN : zmsf_pkg::BK_ZCHK;
      end
      zmsf_pkg::BK_ZCHK: begin
        state_d = zone_hit ? zmsf_pkg::BK_ESCAN : zmsf_pkg::BK_ZRD;
      end
      zmsf_pkg::BK_ESCAN: begin
        if (scan_done) begin
          state_d = zmsf_pkg::BK_ZRD;
        end else if (point_match) begin
          state_d = zmsf_pkg::BK_FIN;
        end
      end
      zmsf_pkg::BK_FIN: begin
        if (out_can) begin
          state_d = zmsf_pkg::BK_IDLE;
        end
      end
      default: state_d = zmsf_pkg::BK_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    q_pop    = 1'b0;
    q_start  = 1'b0;
    do_load  = 1'b0;
    do_clear = 1'b0;
    zrd_en   = 1'b0;
    erd_en   = 1'b0;
    emit     = 1'b0;
    e_found  = 1'b0;
    e_mvld   = 1'b0;
    e_mval   = '0;
    e_last   = 1'b0;
    e_full   = 1'b0;
    unique case (state_q)
      zmsf_pkg::BK_IDLE: begin
        if (q_vld_i) begin
          unique case (q_cmd_i.op)
            zmsf_pkg::OP_LOAD: begin
              if (out_can) begin
                q_pop   = 1'b1;
                emit    = 1'b1;
                e_last  = 1'b1;
                e_full  = is_full;
                do_load = !is_full;
              end
            end
            zmsf_pkg::OP_CLEAR: begin
              if (out_can) begin
                q_pop    = 1'b1;
                emit     = 1'b1;
                e_last   = 1'b1;
                do_clear = 1'b1;
              end
            end
            default: begin
              q_pop   = 1'b1;
              q_start = 1'b1;
            end
          endcase
        end
      end
      zmsf_pkg::BK_ZRD: begin
        zrd_en = (z_q != ztot_q);
      end
      zmsf_pkg::BK_ZCHK: begin
        zrd_en = 1'b0;
      end
      zmsf_pkg::BK_ESCAN: begin
        erd_en = advance && issue_ok;
        // A new match releases the one held before it
        if (range_match && pend_vld_q) begin
          emit   = 1'b1;
          e_mvld = 1'b1;
          e_mval = pend_val_q;
        end
      end
      zmsf_pkg::BK_FIN: begin
        if (out_can) begin
          emit    = 1'b1;
          e_last  = 1'b1;
          e_found = (op_q == zmsf_pkg::OP_POINT) && hit_q;
          e_mvld  = (op_q == zmsf_pkg::OP_RANGE) && pend_vld_q;
          e_mval  = e_mvld ? pend_val_q : '0;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign q_pop_o = q_pop;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= zmsf_pkg::BK_IDLE;
      zone_size_q <= ZsW'(zmsf_pkg::ZONE_SIZE_RST);
      cnt_q       <= '0;
      pos_q       <= '0;
      ztot_q      <= '0;
      out_vld_q   <= 1'b0;
      vld_b_q     <= 1'b0;
      hit_q       <= 1'b0;
      pend_vld_q  <= 1'b0;
      z_q         <= '0;
      idx_q       <= '0;
      end_q       <= '0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        zone_size_q <= cfg_wdata_i;
      end

      // Output register: load a new result or drop the taken one
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end

      // Store bookkeeping
      if (do_clear) begin
        cnt_q  <= '0;
        pos_q  <= '0;
        ztot_q <= '0;
      end else if (do_load) begin
        cnt_q <= nend;
        if (new_zone) begin
          ztot_q <= ztot_q + CntW'(1);
          pos_q  <= ZsW'(1);
        end else begin
          pos_q  <= pos_q + ZsW'(1);
        end
      end

      // Query walk over zones and elements
      if (q_start) begin
        z_q        <= '0;
        hit_q      <= 1'b0;
        pend_vld_q <= 1'b0;
      end
      if (state_q == zmsf_pkg::BK_ZCHK) begin
        if (zone_hit) begin
          idx_q   <= zs_q;
          end_q   <= ze_q;
          vld_b_q <= 1'b0;
        end else begin
          z_q <= z_q + CntW'(1);
        end
      end
      if (state_q == zmsf_pkg::BK_ESCAN) begin
        if (scan_done) begin
          z_q <= z_q + CntW'(1);
        end
        if (advance) begin
          vld_b_q <= issue_ok;
          if (issue_ok) begin
            idx_q <= idx_q + CntW'(1);
          end
        end
        if (range_match) begin
          pend_vld_q <= 1'b1;
        end
        if (point_match) begin
          hit_q <= 1'b1;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (q_start) begin
      op_q <= q_cmd_i.op;
      lo_q <= q_cmd_i.lo;
      hi_q <= q_cmd_i.hi;
    end
    if (do_load) begin
      cur_min_q   <= nmin;
      cur_max_q   <= nmax;
      cur_start_q <= nstart;
    end
    if (range_match) begin
      pend_val_q <= e_key;
    end
    if (emit) begin
      found_q <= e_found;
      mvld_q  <= e_mvld;
      mval_q  <= e_mval;
      last_q  <= e_last;
      full_q  <= e_full;
    end
  end

  // Memory writes and registered reads
  always_ff @(posedge clk_i) begin
    if (do_load) begin
      elem_mem[cnt_q[AddrW-1:0]] <= ld_key;
      zstart_mem[zaddr]          <= nstart;
      zend_mem[zaddr]            <= nend;
      zmin_mem[zaddr]            <= nmin;
      zmax_mem[zaddr]            <= nmax;
    end
    if (zrd_en) begin
      zs_q  <= zstart_mem[z_q[AddrW-1:0]];
      ze_q  <= zend_mem[z_q[AddrW-1:0]];
      zmn_q <= zmin_mem[z_q[AddrW-1:0]];
      zmx_q <= zmax_mem[z_q[AddrW-1:0]];
    end
    if (erd_en) begin
      erd_q <= elem_mem[idx_q[AddrW-1:0]];
    end
  end

  assign out_valid_o   = out_vld_q;
  assign found_o       = found_q;
  assign match_valid_o = mvld_q;
  assign match_value_o = mval_q;
  assign last_o        = last_q;
  assign store_full_o  = full_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_ELEMENTS))
    else $error("element count beyond capacity");

  a_zones_le_elems: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ztot_q <= cnt_q)
    else $error("more zones than elements");

  a_scan_in_zone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == zmsf_pkg::BK_ESCAN) |-> (idx_q <= end_q))
    else $error("element scan ran past its zone");

  a_pend_range_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_vld_q && (state_q != zmsf_pkg::BK_IDLE)) |-> (op_q == zmsf_pkg::OP_RANGE))
    else $error("held match outside a range query");

  a_mid_result_is_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !last_q) |-> mvld_q)
    else $error("non-final result without a match");
`endif

endmodule
